>>> hw/rtl/bsm_pkg.sv
// Shared constants, register indexes and types of the battery sag monitor.
// Used by every RTL file of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bsm_pkg;

    localparam int FRAC_BITS          = 16;
    localparam int BSM_NUM_CANDIDATES = 12;
    localparam int BSM_CHARGE_SHIFT   = 22;
    localparam int VCOMP_SHIFT        = FRAC_BITS - 4;
    localparam int SCORE_W            = 58;

    localparam logic [15:0] THROTTLE_PAUSE = 16'd6553;
    localparam logic [11:0] ABS_FLOOR_MV   = 12'd2700;
    localparam logic [10:0] STEP_MV        = 11'd100;
    localparam logic [19:0] ENERGY_CLAMP   = 20'hFFFFF;

    localparam logic [2:0] REG_CELL_COUNT    = 3'd0;
    localparam logic [2:0] REG_LOW_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_FILTERED_ONLY = 3'd2;
    localparam logic [2:0] REG_DISPLAY_ALPHA = 3'd3;
    localparam logic [2:0] REG_DECAY_COEFF   = 3'd4;
    localparam logic [2:0] REG_HYSTERESIS    = 3'd5;
    localparam logic [2:0] REG_HIGHPASS      = 3'd6;
    localparam logic [2:0] REG_SCORE_COEFF   = 3'd7;

    localparam logic [3:0]  RST_CELL_COUNT    = 4'd1;
    localparam logic [12:0] RST_LOW_THRESHOLD = 13'd3300;
    localparam logic [15:0] RST_DISPLAY_ALPHA = 16'd2048;
    localparam logic [15:0] RST_DECAY_COEFF   = 16'd65532;
    localparam logic [9:0]  RST_HYSTERESIS    = 10'd100;
    localparam logic [15:0] RST_HIGHPASS      = 16'd65470;
    localparam logic [15:0] RST_SCORE_COEFF   = 16'd65535;

    typedef struct packed {
        logic signed [31:0]  prev_in;
        logic signed [31:0]  prev_out;
        logic [SCORE_W-1:0]  score;
    } cand_entry_t;

endpackage

`default_nettype wire

>>> hw/rtl/bsm_cand_ram.sv
// Candidate state memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Uses bsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsm_cand_ram
    import bsm_pkg::*;
#(
    parameter int NUM_CANDIDATES = BSM_NUM_CANDIDATES,
    parameter int AW             = $clog2(NUM_CANDIDATES)
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        we,
    input  wire logic [AW-1:0] waddr,
    input  wire cand_entry_t wdata,
    input  wire logic [AW-1:0] raddr,
    output cand_entry_t      rdata
);

    cand_entry_t mem [NUM_CANDIDATES];
    logic [NUM_CANDIDATES-1:0] valid_reg;
    cand_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bsm_div.sv
// Restoring divider of a 16-bit value by a 4-bit cell count, one bit per cycle.
// Uses bsm_pkg for the house conventions only.
`timescale 1ns / 1ps
`default_nettype none

module bsm_div
    import bsm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] dividend,
    input  wire logic [3:0]  divisor,
    output logic             done,
    output logic [15:0]      quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [3:0]  rem_reg;
    logic [15:0] quo_reg;
    logic [3:0]  div_reg;
    logic [4:0]  trial;
    logic        fits;

    assign trial = {rem_reg, quo_reg[15]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 4'(trial - {1'b0, div_reg}) : trial[3:0];
            quo_reg <= {quo_reg[14:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hw/rtl/battery_sag_compensated_monitor_top.sv
// Battery sag compensated monitor top; instantiates bsm_cand_ram and bsm_div, uses bsm_pkg.
// A transaction runs the filter steps, scores one candidate while the throttle is
// above the pause level, sweeps the candidate memory for the minimum at the end of
// a round, and then runs the two 16-step serial divisions.
// One transaction at a time; the next is taken while the result waits.
// Reset clears all tracks, candidate state and config to defaults at once.
`timescale 1ns / 1ps
`default_nettype none

module battery_sag_compensated_monitor_top
    import bsm_pkg::*;
#(
    parameter int NUM_CANDIDATES = BSM_NUM_CANDIDATES,
    parameter int CHARGE_SHIFT   = BSM_CHARGE_SHIFT
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pack_voltage_mv[15:0], pack_current_ma[31:16], throttle_sum[47:32]
    input  wire logic [47:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // voltage_filtered_mv[15:0], current_filtered_ma[31:16], cell_average_mv[47:32],
    // compensated_mv[63:48], compensated_cell_mv[79:64], gain_step[83:80],
    // charge_drawn[115:84], low_battery[116], zero[119:117]
    output logic [119:0]      m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    localparam int AW = $clog2(NUM_CANDIDATES);
    localparam int CW = $clog2(NUM_CANDIDATES + 1);
    localparam int BW = $clog2(NUM_CANDIDATES + 1);

    typedef enum logic [17:0] {
        ST_IDLE    = 18'h00001,
        ST_F_CUR   = 18'h00002,
        ST_F_VOLT  = 18'h00004,
        ST_F_DECAY = 18'h00008,
        ST_F_THR   = 18'h00010,
        ST_TVOLT   = 18'h00020,
        ST_C_READ  = 18'h00040,
        ST_C_HP    = 18'h00080,
        ST_C_ANS   = 18'h00100,
        ST_C_SQ    = 18'h00200,
        ST_C_SG    = 18'h00400,
        ST_C_WR    = 18'h00800,
        ST_SRCH    = 18'h01000,
        ST_COMP    = 18'h02000,
        ST_LOW     = 18'h04000,
        ST_DIV_V   = 18'h08000,
        ST_DIV_C   = 18'h10000,
        ST_FINISH  = 18'h20000
    } state_t;

    function automatic logic [26:0] gain_term(input logic [4:0] k, input logic [15:0] t);
        logic [10:0] k100;
        k100 = {6'b0, k} * STEP_MV;
        return {16'b0, k100} * {11'b0, t};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sh0_7FFF_FFFF)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -36'sh0_8000_0000)
        begin
            return -32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    state_t state_reg;

    logic [3:0]  cell_count_reg;
    logic [12:0] thr_mv_reg;
    logic        fonly_reg;
    logic [15:0] alpha_reg;
    logic [15:0] decay_reg;
    logic [9:0]  hyst_reg;
    logic [15:0] hp_reg;
    logic [15:0] sc_reg;

    logic [15:0] v_in_reg;
    logic [15:0] i_in_reg;
    logic [15:0] th_in_reg;

    logic [31:0] vtrack_reg;
    logic [31:0] ctrack_reg;
    logic [31:0] thtrack_reg;
    logic [31:0] dtrack_reg;
    logic [47:0] acc_reg;
    logic signed [35:0] tv_reg;
    logic [AW-1:0] ptr_reg;
    logic [BW-1:0] best_reg;
    logic          low_reg;

    logic signed [24:0] vcomp_reg;
    cand_entry_t        cand_reg;
    logic signed [33:0] diff_reg;
    logic signed [48:0] prod_reg;
    logic signed [35:0] ans_reg;
    logic [39:0]        e_reg;
    logic [58:0]        phi_reg;
    logic [16:0]        plo_reg;
    logic [56:0]        eg_reg;

    logic [CW-1:0]      srch_idx_reg;
    logic               cmp_vld_reg;
    logic [AW-1:0]      cmp_idx_reg;
    logic [SCORE_W-1:0] min_reg;

    logic signed [37:0] comp_reg;
    logic [15:0]        comp_mv_reg;
    logic [15:0]        cellavg_reg;
    logic [15:0]        compcell_reg;

    logic [119:0] m_tdata_reg;
    logic         m_tvalid_reg;

    // Shared one-pole filter step.
    logic [31:0] lp_y;
    logic [31:0] lp_x;
    logic [16:0] lp_g;
    logic        lp_up;
    logic [31:0] lp_diff;
    logic [48:0] lp_prod;
    logic [31:0] lp_res;

    always_comb
    begin
        unique case (state_reg)
            ST_F_CUR:
            begin
                lp_y = ctrack_reg;
                lp_x = {i_in_reg, 16'b0};
                lp_g = {1'b0, alpha_reg};
            end
            ST_F_VOLT:
            begin
                lp_y = vtrack_reg;
                lp_x = {v_in_reg, 16'b0};
                lp_g = {1'b0, alpha_reg};
            end
            ST_F_DECAY:
            begin
                lp_y = dtrack_reg;
                lp_x = vtrack_reg;
                lp_g = 17'h10000 - {1'b0, decay_reg};
            end
            default:
            begin
                lp_y = thtrack_reg;
                lp_x = {th_in_reg, 16'b0};
                lp_g = {1'b0, alpha_reg};
            end
        endcase
    end

    assign lp_up   = lp_x >= lp_y;
    assign lp_diff = lp_up ? lp_x - lp_y : lp_y - lp_x;
    assign lp_prod = {17'b0, lp_diff} * {32'b0, lp_g};
    assign lp_res  = lp_up ? lp_y + lp_prod[47:16] : lp_y - lp_prod[47:16];

    logic [48:0] acc_sum;
    assign acc_sum = {1'b0, acc_reg} + {33'b0, ctrack_reg[31:16]};

    logic [34:0]        v5;
    logic signed [35:0] tvn;
    logic signed [35:0] tv_next;
    assign v5      = {1'b0, vtrack_reg, 2'b0} + {3'b0, vtrack_reg};
    assign tvn     = $signed({1'b0, v5}) - $signed({4'b0, dtrack_reg});
    assign tv_next = (tvn + (tvn < 0 ? 36'sd3 : 36'sd0)) >>> 2;

    logic [15:0] t_now;
    assign t_now = thtrack_reg[31:16];

    logic signed [36:0] vsum;
    logic signed [36:0] vsum_q;
    assign vsum   = {tv_reg[35], tv_reg} + $signed({10'b0, gain_term(5'(ptr_reg), t_now)});
    assign vsum_q = (vsum + (vsum < 0 ? 37'sd4095 : 37'sd0)) >>> VCOMP_SHIFT;

    cand_entry_t ram_rdata;
    cand_entry_t ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic          ram_we;

    logic signed [32:0] hpq;
    assign hpq = 33'((prod_reg + (prod_reg < 0 ? 49'sd65535 : 49'sd0)) >>> 16);

    logic [19:0] a_abs;
    always_comb
    begin
        if (ans_reg > 36'sd1048575 || ans_reg < -36'sd1048575)
        begin
            a_abs = ENERGY_CLAMP;
        end
        else if (ans_reg < 0)
        begin
            a_abs = 20'(-ans_reg);
        end
        else
        begin
            a_abs = ans_reg[19:0];
        end
    end

    logic [16:0] sg;
    assign sg = 17'h10000 - {1'b0, sc_reg};

    logic [59:0] s_new;
    assign s_new = {2'b0, cand_reg.score} - {1'b0, phi_reg} - {43'b0, plo_reg}
                 + {3'b0, eg_reg};

    assign ram_we    = state_reg == ST_C_WR;
    assign ram_raddr = (state_reg == ST_SRCH) ? srch_idx_reg[AW-1:0] : ptr_reg;
    assign ram_wdata = '{prev_in:  sat32({{11{vcomp_reg[24]}}, vcomp_reg}),
                         prev_out: sat32(ans_reg),
                         score:    s_new[SCORE_W-1:0]};

    bsm_cand_ram #(
        .NUM_CANDIDATES(NUM_CANDIDATES),
        .AW(AW)
    ) u_ram (
        .clk(clk),
        .rst_n(rst_n),
        .we(ram_we),
        .waddr(ptr_reg),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    logic [CW-1:0] ptr_inc;
    assign ptr_inc = CW'(ptr_reg) + CW'(1);

    // Low battery decision and compensated outputs.
    logic [3:0]  n4;
    logic [16:0] thrn;
    logic [13:0] lim;
    logic [17:0] limn;
    logic [15:0] floorn;
    logic        low_next;
    logic [15:0] comp_mv_next;
    assign n4     = (cell_count_reg == 4'd0) ? 4'd1 : cell_count_reg;
    assign thrn   = {4'b0, thr_mv_reg} * {13'b0, n4};
    assign lim    = {1'b0, thr_mv_reg} + (low_reg ? {4'b0, hyst_reg} : 14'd0);
    assign limn   = {4'b0, lim} * {14'b0, n4};
    assign floorn = {4'b0, ABS_FLOOR_MV} * {12'b0, n4};

    always_comb
    begin
        if (fonly_reg)
        begin
            low_next = {1'b0, vtrack_reg} < {thrn, 16'b0};
        end
        else
        begin
            low_next = (comp_reg < $signed({4'b0, limn, 16'b0}))
                    || (vtrack_reg < {floorn, 16'b0});
        end
        if (comp_reg < 0)
        begin
            comp_mv_next = '0;
        end
        else if (|comp_reg[37:32])
        begin
            comp_mv_next = 16'hFFFF;
        end
        else
        begin
            comp_mv_next = comp_reg[31:16];
        end
    end

    logic        div_start;
    logic [15:0] div_dividend;
    logic        div_done;
    logic [15:0] div_quotient;
    assign div_start    = (state_reg == ST_LOW) || (state_reg == ST_DIV_V && div_done);
    assign div_dividend = (state_reg == ST_LOW) ? vtrack_reg[31:16] : comp_mv_reg;

    bsm_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(div_dividend),
        .divisor(n4),
        .done(div_done),
        .quotient(div_quotient)
    );

    logic [47:0] acc_sh;
    logic [31:0] chg;
    logic [4:0]  best_ext;
    logic [3:0]  gain_out;
    assign acc_sh   = acc_reg >> CHARGE_SHIFT;
    assign chg      = (|acc_sh[47:32]) ? 32'hFFFF_FFFF : acc_sh[31:0];
    assign best_ext = 5'(best_reg);
    assign gain_out = (best_ext > 5'd15) ? 4'hF : best_ext[3:0];

    logic out_load;
    assign out_load = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_count_reg <= RST_CELL_COUNT;
            thr_mv_reg     <= RST_LOW_THRESHOLD;
            fonly_reg      <= 1'b0;
            alpha_reg      <= RST_DISPLAY_ALPHA;
            decay_reg      <= RST_DECAY_COEFF;
            hyst_reg       <= RST_HYSTERESIS;
            hp_reg         <= RST_HIGHPASS;
            sc_reg         <= RST_SCORE_COEFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CELL_COUNT:    cell_count_reg <= cfg_data[3:0];
                REG_LOW_THRESHOLD: thr_mv_reg     <= cfg_data[12:0];
                REG_FILTERED_ONLY: fonly_reg      <= cfg_data[0];
                REG_DISPLAY_ALPHA: alpha_reg      <= cfg_data;
                REG_DECAY_COEFF:   decay_reg      <= cfg_data;
                REG_HYSTERESIS:    hyst_reg       <= cfg_data[9:0];
                REG_HIGHPASS:      hp_reg         <= cfg_data;
                REG_SCORE_COEFF:   sc_reg         <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            vtrack_reg   <= '0;
            ctrack_reg   <= '0;
            thtrack_reg  <= '0;
            dtrack_reg   <= '0;
            acc_reg      <= '0;
            ptr_reg      <= '0;
            best_reg     <= '0;
            low_reg      <= 1'b0;
            srch_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_F_CUR;
                    end
                end
                ST_F_CUR:
                begin
                    ctrack_reg <= lp_res;
                    state_reg  <= ST_F_VOLT;
                end
                ST_F_VOLT:
                begin
                    vtrack_reg <= lp_res;
                    acc_reg    <= acc_sum[48] ? 48'hFFFF_FFFF_FFFF : acc_sum[47:0];
                    state_reg  <= ST_F_DECAY;
                end
                ST_F_DECAY:
                begin
                    dtrack_reg <= lp_res;
                    state_reg  <= ST_F_THR;
                end
                ST_F_THR:
                begin
                    thtrack_reg <= lp_res;
                    state_reg   <= ST_TVOLT;
                end
                ST_TVOLT:
                begin
                    state_reg <= (t_now > THROTTLE_PAUSE) ? ST_C_READ : ST_COMP;
                end
                ST_C_READ:
                begin
                    state_reg <= ST_C_HP;
                end
                ST_C_HP:
                begin
                    state_reg <= ST_C_ANS;
                end
                ST_C_ANS:
                begin
                    state_reg <= ST_C_SQ;
                end
                ST_C_SQ:
                begin
                    state_reg <= ST_C_SG;
                end
                ST_C_SG:
                begin
                    state_reg <= ST_C_WR;
                end
                ST_C_WR:
                begin
                    srch_idx_reg <= '0;
                    cmp_vld_reg  <= 1'b0;
                    if (ptr_inc >= CW'(NUM_CANDIDATES))
                    begin
                        ptr_reg   <= '0;
                        state_reg <= ST_SRCH;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_inc[AW-1:0];
                        state_reg <= ST_COMP;
                    end
                end
                ST_SRCH:
                begin
                    if (srch_idx_reg < CW'(NUM_CANDIDATES))
                    begin
                        srch_idx_reg <= srch_idx_reg + CW'(1);
                        cmp_vld_reg  <= 1'b1;
                        cmp_idx_reg  <= srch_idx_reg[AW-1:0];
                    end
                    else
                    begin
                        cmp_vld_reg <= 1'b0;
                    end
                    if (cmp_vld_reg)
                    begin
                        if (cmp_idx_reg != '0 && ram_rdata.score < min_reg)
                        begin
                            best_reg <= BW'(cmp_idx_reg) + BW'(1);
                        end
                        if (cmp_idx_reg == AW'(NUM_CANDIDATES - 1))
                        begin
                            state_reg <= ST_COMP;
                        end
                    end
                end
                ST_COMP:
                begin
                    state_reg <= ST_LOW;
                end
                ST_LOW:
                begin
                    low_reg   <= low_next;
                    state_reg <= ST_DIV_V;
                end
                ST_DIV_V:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_DIV_C;
                    end
                end
                ST_DIV_C:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && state_reg == ST_IDLE)
        begin
            v_in_reg  <= s_tdata[15:0];
            i_in_reg  <= s_tdata[31:16];
            th_in_reg <= s_tdata[47:32];
        end
        if (state_reg == ST_TVOLT)
        begin
            tv_reg <= tv_next;
        end
        if (state_reg == ST_C_READ)
        begin
            vcomp_reg <= vsum_q[24:0];
        end
        if (state_reg == ST_C_HP)
        begin
            cand_reg <= ram_rdata;
            diff_reg <= {{9{vcomp_reg[24]}}, vcomp_reg}
                      - {{2{ram_rdata.prev_in[31]}}, ram_rdata.prev_in};
            prod_reg <= $signed({32'b0, hp_reg}) * {{17{ram_rdata.prev_out[31]}},
                                                   ram_rdata.prev_out};
        end
        if (state_reg == ST_C_ANS)
        begin
            ans_reg <= {{2{diff_reg[33]}}, diff_reg} + {{3{hpq[32]}}, hpq};
        end
        if (state_reg == ST_C_SQ)
        begin
            e_reg   <= {20'b0, a_abs} * {20'b0, a_abs};
            phi_reg <= {17'b0, cand_reg.score[SCORE_W-1:16]} * {42'b0, sg};
        end
        if (state_reg == ST_C_SG)
        begin
            eg_reg  <= {17'b0, e_reg} * {40'b0, sg};
            plo_reg <= 17'(({17'b0, cand_reg.score[15:0]} * {16'b0, sg}) >> 16);
        end
        if (state_reg == ST_SRCH && cmp_vld_reg)
        begin
            if (cmp_idx_reg == '0 || ram_rdata.score < min_reg)
            begin
                min_reg <= ram_rdata.score;
            end
        end
        if (state_reg == ST_COMP)
        begin
            comp_reg <= {{2{tv_reg[35]}}, tv_reg}
                      + $signed({11'b0, gain_term(5'(best_reg), t_now)});
        end
        if (state_reg == ST_LOW)
        begin
            comp_mv_reg <= comp_mv_next;
        end
        if (state_reg == ST_DIV_V && div_done)
        begin
            cellavg_reg <= div_quotient;
        end
        if (state_reg == ST_DIV_C && div_done)
        begin
            compcell_reg <= div_quotient;
        end
        if (out_load)
        begin
            m_tdata_reg <= {3'b0, low_reg, chg, gain_out, compcell_reg, comp_mv_reg,
                            cellavg_reg, ctrack_reg[31:16], vtrack_reg[31:16]};
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_F_CUR))
        else $error("accepted transaction did not start the filter sequence");

    a_div_done_place: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_V || state_reg == ST_DIV_C))
        else $error("divider finished outside a divide state");

    a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
        (best_reg <= BW'(NUM_CANDIDATES)) && (CW'(ptr_reg) < CW'(NUM_CANDIDATES)))
        else $error("candidate pointer or best candidate out of range");

    a_ram_write_place: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (state_reg == ST_SRCH || state_reg == ST_COMP))
        else $error("candidate write not followed by search or compensation");

endmodule

`default_nettype wire
